[sv/aapr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package aapr_pkg;

    // Field widths of the stream and register payloads.
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int ANGLE_W = 19;
    localparam int SCALE_W = 18;
    localparam int CFG_W   = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_W-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_W-1:0] REG_REF_X    = 3'd3;
    localparam logic [CFG_W-1:0] REG_REF_Y    = 3'd4;
    localparam logic [CFG_W-1:0] REG_REF_Z    = 3'd5;
    localparam logic [CFG_W-1:0] REG_ANGLE    = 3'd6;
    localparam logic [CFG_W-1:0] REG_SCALE    = 3'd7;

    // Fixed-point constants.
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint ONE_Q28 = 64'sd268435456;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    // Taylor series: the last term index, and the steps of the divider.
    localparam logic [3:0] SERIES_LAST = 4'd13;
    localparam logic [5:0] DIV_LAST    = 6'd35;

    // Matrix build sequencer.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_TAKE,
        ST_SER_MUL,
        ST_SER_DIVLD,
        ST_SER_DIV,
        ST_SER_ACC,
        ST_AX_MUL,
        ST_AX_TAKE,
        ST_UU_MUL,
        ST_UU_TAKE,
        ST_W_MUL,
        ST_W_TAKE,
        ST_V_MUL,
        ST_V_TAKE,
        ST_ENT_WR
    } build_state_t;

endpackage

`default_nettype wire

[sv/axis_angle_point_rotator.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  s_tdata: point_x, point_y, point_z
// m_*       out        m_tvalid / m_tready  m_tdata: rotated_x, rotated_y, rotated_z
// cfg_*     in         cfg_valid / cfg_ready cfg_index, cfg_data (register write)
//
// Points stream at one item per cycle while no build runs and m_tready does not stall,
// through subtract, nine products, row sums, origin add and saturation into the output register.
// Each stage moves when its successor has room, so a stall on m_tready loses nothing.
// Every register write rebuilds the rotation matrix with one shared multiplier and
// a bit-serial divider for the sine and cosine series; while the build runs,
// s_tready is low. Reset is synchronous; it leaves the identity matrix.

module axis_angle_point_rotator (
    input  wire         aclk,
    input  wire         aresetn,
    // point_x [31:0], point_y [63:32], point_z [95:64]
    input  wire  [95:0] s_tdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // rotated_x [31:0], rotated_y [63:32], rotated_z [95:64]
    output logic [95:0] m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire  [2:0]  cfg_index,
    input  wire  [31:0] cfg_data,
    input  wire         cfg_valid,
    output logic        cfg_ready
);
    import aapr_pkg::*;

    // Configuration registers.
    logic signed [COORD_W-1:0] origin_reg [0:2];
    logic signed [COORD_W-1:0] ref_reg    [0:2];
    logic signed [ANGLE_W-1:0] ang_reg;
    logic        [SCALE_W-1:0] scale_reg;

    // Rotation matrix, row major, Q2.30.
    logic signed [31:0] mat_reg [0:8];

    // Build sequencer state and datapath.
    build_state_t state_reg, state_next;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;
    logic        [32:0] a2_reg;
    logic        [31:0] t_reg;
    logic signed [36:0] sum_reg;
    logic        [4:0]  n_reg;
    logic        [3:0]  term_reg;
    logic               cos_reg;
    logic        [35:0] quo_reg;
    logic        [9:0]  rem_reg;
    logic        [9:0]  div_reg;
    logic        [5:0]  cnt_reg;
    logic signed [31:0] s_reg, c_reg;
    logic signed [32:0] omc_reg;
    logic signed [31:0] u0_reg, u1_reg, u2_reg;
    logic signed [31:0] uu_reg, v_reg;
    logic signed [32:0] w_reg;
    logic        [1:0]  i_reg, j_reg;

    logic        [18:0] ang_mag;
    logic        [30:0] a_q28;
    logic signed [32:0] d_sel;
    logic signed [31:0] u_i, u_j, u_k;
    logic        [1:0]  k_idx;
    logic        [3:0]  ent_idx;
    logic        [10:0] rem_sh;
    logic               div_ge;
    logic        [10:0] rem_sub;
    logic signed [36:0] sum_new;
    logic signed [38:0] ser_sc, ser_sgn;
    logic signed [31:0] ser_cl;
    logic signed [67:0] prod_r30, prod_r2;
    logic signed [37:0] rnd30;
    logic signed [65:0] ax_rnd;
    logic signed [31:0] ax_cl;
    logic signed [32:0] ent_add;
    logic signed [33:0] ent_sum;
    logic signed [31:0] ent_cl;
    logic               cross_plus;
    logic               busy;

    // Point pipeline.
    logic               v1_reg, v2_reg, v3_reg, vo_reg;
    logic               rdy1, rdy2, rdy3, rdy_o;
    logic signed [DIFF_W-1:0]  q_reg   [0:2];
    logic signed [48:0]        pr_reg  [0:8];
    logic signed [36:0]        rs_reg  [0:2];
    logic signed [COORD_W-1:0] out_reg [0:2];
    logic signed [64:0]        mp      [0:8];
    logic signed [50:0]        acc     [0:2];
    logic signed [50:0]        acc_r   [0:2];
    logic signed [37:0]        fin     [0:2];
    logic signed [COORD_W-1:0] fin_cl  [0:2];

    // Configuration writes are always taken; each one restarts the build.
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                origin_reg[r] <= '0;
                ref_reg[r]    <= '0;
            end
            ang_reg   <= '0;
            scale_reg <= 18'd65536;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_reg[0] <= cfg_data;
                REG_ORIGIN_Y: origin_reg[1] <= cfg_data;
                REG_ORIGIN_Z: origin_reg[2] <= cfg_data;
                REG_REF_X:    ref_reg[0]    <= cfg_data;
                REG_REF_Y:    ref_reg[1]    <= cfg_data;
                REG_REF_Z:    ref_reg[2]    <= cfg_data;
                REG_ANGLE:    ang_reg       <= cfg_data[ANGLE_W-1:0];
                REG_SCALE:    scale_reg     <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // Operand selection for the build.
    always_comb begin
        ang_mag = ang_reg[ANGLE_W-1] ? 19'(-ang_reg) : 19'(ang_reg);
        a_q28   = {ang_mag, 12'b0};
        d_sel   = {origin_reg[i_reg][31], origin_reg[i_reg]}
                - {ref_reg[i_reg][31], ref_reg[i_reg]};
        k_idx   = 2'(2'd3 - i_reg - j_reg);
        ent_idx = 4'(i_reg) * 4'd3 + 4'(j_reg);
        unique case (i_reg)
            2'd0:    u_i = u0_reg;
            2'd1:    u_i = u1_reg;
            default: u_i = u2_reg;
        endcase
        unique case (j_reg)
            2'd0:    u_j = u0_reg;
            2'd1:    u_j = u1_reg;
            default: u_j = u2_reg;
        endcase
        unique case (k_idx)
            2'd0:    u_k = u0_reg;
            2'd1:    u_k = u1_reg;
            default: u_k = u2_reg;
        endcase
    end

    // Shared multiplier inputs by sequencer step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ_MUL: begin
                mul_a = $signed({3'b0, a_q28});
                mul_b = $signed({3'b0, a_q28});
            end
            ST_SER_MUL: begin
                mul_a = $signed({2'b0, t_reg});
                mul_b = $signed({1'b0, a2_reg});
            end
            ST_AX_MUL: begin
                mul_a = {d_sel[32], d_sel};
                mul_b = $signed({16'b0, scale_reg});
            end
            ST_UU_MUL: begin
                mul_a = {{2{u_i[31]}}, u_i};
                mul_b = {{2{u_j[31]}}, u_j};
            end
            ST_W_MUL: begin
                mul_a = {omc_reg[32], omc_reg};
                mul_b = {{2{uu_reg[31]}}, uu_reg};
            end
            ST_V_MUL: begin
                mul_a = {{2{s_reg[31]}}, s_reg};
                mul_b = {{2{u_k[31]}}, u_k};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider step, series accumulation and the rounding and clamping of products.
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[35]};
        div_ge  = (rem_sh >= {1'b0, div_reg});
        rem_sub = rem_sh - {1'b0, div_reg};

        sum_new = term_reg[0] ? sum_reg - $signed({1'b0, quo_reg})
                              : sum_reg + $signed({1'b0, quo_reg});
        ser_sc  = $signed({sum_new, 2'b00});
        ser_sgn = (!cos_reg && ang_reg[ANGLE_W-1]) ? -ser_sc : ser_sc;
        if (ser_sgn > ONE_Q30)
            ser_cl = 32'(ONE_Q30);
        else if (ser_sgn < -ONE_Q30)
            ser_cl = 32'(-ONE_Q30);
        else
            ser_cl = ser_sgn[31:0];

        prod_r30 = prod_reg + 68'sd536870912;
        rnd30    = prod_r30[67:30];
        prod_r2  = prod_reg + 68'sd2;
        ax_rnd   = prod_r2[67:2];
        if (ax_rnd > ONE_Q30)
            ax_cl = 32'(ONE_Q30);
        else if (ax_rnd < -ONE_Q30)
            ax_cl = 32'(-ONE_Q30);
        else
            ax_cl = ax_rnd[31:0];

        // The cross-product term is positive below the skew pattern.
        cross_plus = (i_reg == 2'd1 && j_reg == 2'd0) || (i_reg == 2'd2 && j_reg == 2'd1)
                  || (i_reg == 2'd0 && j_reg == 2'd2);
        if (i_reg == j_reg)
            ent_add = {c_reg[31], c_reg};
        else if (cross_plus)
            ent_add = {v_reg[31], v_reg};
        else
            ent_add = -{v_reg[31], v_reg};
        ent_sum = {w_reg[32], w_reg} + {ent_add[32], ent_add};
        if (ent_sum > I32_MAX)
            ent_cl = 32'(I32_MAX);
        else if (ent_sum < I32_MIN)
            ent_cl = 32'(I32_MIN);
        else
            ent_cl = ent_sum[31:0];
    end

    // Sequencer state register.
    always_ff @(posedge aclk) begin
        if (!aresetn)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      state_next = ST_IDLE;
            ST_SQ_MUL:    state_next = ST_SQ_TAKE;
            ST_SQ_TAKE:   state_next = ST_SER_MUL;
            ST_SER_MUL:   state_next = ST_SER_DIVLD;
            ST_SER_DIVLD: state_next = ST_SER_DIV;
            ST_SER_DIV:   state_next = (cnt_reg == DIV_LAST) ? ST_SER_ACC : ST_SER_DIV;
            ST_SER_ACC:   state_next = (term_reg == SERIES_LAST && cos_reg) ? ST_AX_MUL
                                                                           : ST_SER_MUL;
            ST_AX_MUL:    state_next = ST_AX_TAKE;
            ST_AX_TAKE:   state_next = (i_reg == 2'd2) ? ST_UU_MUL : ST_AX_MUL;
            ST_UU_MUL:    state_next = ST_UU_TAKE;
            ST_UU_TAKE:   state_next = ST_W_MUL;
            ST_W_MUL:     state_next = ST_W_TAKE;
            ST_W_TAKE:    state_next = (i_reg == j_reg) ? ST_ENT_WR : ST_V_MUL;
            ST_V_MUL:     state_next = ST_V_TAKE;
            ST_V_TAKE:    state_next = ST_ENT_WR;
            ST_ENT_WR:    state_next = (i_reg == 2'd2 && j_reg == 2'd2) ? ST_IDLE
                                                                         : ST_UU_MUL;
            default:      state_next = ST_IDLE;
        endcase
        if (cfg_valid && cfg_ready)
            state_next = ST_SQ_MUL;
    end

    // Build datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            ST_SQ_TAKE: begin
                a2_reg   <= prod_reg[60:28];
                t_reg    <= {1'b0, a_q28};
                sum_reg  <= $signed({6'b0, a_q28});
                n_reg    <= 5'd2;
                term_reg <= 4'd1;
                cos_reg  <= 1'b0;
            end
            ST_SER_DIVLD: begin
                quo_reg <= prod_reg[63:28];
                rem_reg <= '0;
                cnt_reg <= '0;
                div_reg <= 10'(n_reg) * 10'(n_reg + 5'd1);
            end
            ST_SER_DIV: begin
                rem_reg <= div_ge ? rem_sub[9:0] : rem_sh[9:0];
                quo_reg <= {quo_reg[34:0], div_ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_SER_ACC: begin
                if (term_reg == SERIES_LAST) begin
                    if (!cos_reg) begin
                        // Sine done; the cosine series starts from one.
                        s_reg    <= ser_cl;
                        t_reg    <= 32'(ONE_Q28);
                        sum_reg  <= 37'(ONE_Q28);
                        n_reg    <= 5'd1;
                        term_reg <= 4'd1;
                        cos_reg  <= 1'b1;
                    end else begin
                        c_reg   <= ser_cl;
                        omc_reg <= 33'(ONE_Q30) - {ser_cl[31], ser_cl};
                        i_reg   <= 2'd0;
                    end
                end else begin
                    t_reg    <= quo_reg[31:0];
                    sum_reg  <= sum_new;
                    n_reg    <= n_reg + 5'd2;
                    term_reg <= term_reg + 4'd1;
                end
            end
            ST_AX_TAKE: begin
                unique case (i_reg)
                    2'd0:    u0_reg <= ax_cl;
                    2'd1:    u1_reg <= ax_cl;
                    default: u2_reg <= ax_cl;
                endcase
                if (i_reg == 2'd2) begin
                    i_reg <= 2'd0;
                    j_reg <= 2'd0;
                end else begin
                    i_reg <= i_reg + 2'd1;
                end
            end
            ST_UU_TAKE: uu_reg <= rnd30[31:0];
            ST_W_TAKE:  w_reg  <= rnd30[32:0];
            ST_V_TAKE:  v_reg  <= rnd30[31:0];
            ST_ENT_WR: begin
                if (j_reg == 2'd2) begin
                    j_reg <= 2'd0;
                    i_reg <= i_reg + 2'd1;
                end else begin
                    j_reg <= j_reg + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Matrix entries; reset leaves the identity, which the reset registers give.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int e = 0; e < 9; e++)
                mat_reg[e] <= (e % 4 == 0) ? 32'(ONE_Q30) : 32'sd0;
        end else if (state_reg == ST_ENT_WR) begin
            mat_reg[ent_idx] <= ent_cl;
        end
    end

    // Stage handshakes: a stage moves when it is empty or its successor moves.
    assign rdy_o    = !vo_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_o;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1 && !busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1)
                v1_reg <= s_tvalid && !busy;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_o)
                vo_reg <= v3_reg;
        end
    end

    // Products, row sums and the final origin add with saturation.
    always_comb begin
        for (int e = 0; e < 9; e++)
            mp[e] = mat_reg[e] * q_reg[e % 3];
        for (int r = 0; r < 3; r++) begin
            acc[r] = {{2{pr_reg[3*r][48]}}, pr_reg[3*r]}
                   + {{2{pr_reg[3*r+1][48]}}, pr_reg[3*r+1]}
                   + {{2{pr_reg[3*r+2][48]}}, pr_reg[3*r+2]};
            acc_r[r] = acc[r] + 51'sd8192;
            fin[r] = {rs_reg[r][36], rs_reg[r]} + {{6{origin_reg[r][31]}}, origin_reg[r]};
            if (fin[r] > I32_MAX)
                fin_cl[r] = 32'(I32_MAX);
            else if (fin[r] < I32_MIN)
                fin_cl[r] = 32'(I32_MIN);
            else
                fin_cl[r] = fin[r][31:0];
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            q_reg[0] <= {s_tdata[31], s_tdata[31:0]}
                      - {origin_reg[0][31], origin_reg[0]};
            q_reg[1] <= {s_tdata[63], s_tdata[63:32]}
                      - {origin_reg[1][31], origin_reg[1]};
            q_reg[2] <= {s_tdata[95], s_tdata[95:64]}
                      - {origin_reg[2][31], origin_reg[2]};
        end
        if (rdy2) begin
            for (int e = 0; e < 9; e++)
                pr_reg[e] <= mp[e][64:16];
        end
        if (rdy3) begin
            for (int r = 0; r < 3; r++)
                rs_reg[r] <= acc_r[r][50:14];
        end
        if (rdy_o) begin
            for (int r = 0; r < 3; r++)
                out_reg[r] <= fin_cl[r];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};

endmodule

`default_nettype wire
